// ----- design/mrt_pkg.sv -----
// ----------------------------------------------------------------------------
// mrt_pkg: shared types and constants of the multichannel reload timer
// transaction structs, opcodes, register map and control-word bit layout
// ----------------------------------------------------------------------------
package mrt_pkg;

	// largest channel count the register map has room for
	localparam int MAX_CHANNELS = 5;
	localparam int CTL_W        = 23;
	localparam int CHAN_W       = 3;

	// register byte offsets
	localparam logic [6:0] ADDR_PRESCALE  = 7'h00;
	localparam logic [6:0] ADDR_DIVIDER   = 7'h04;
	localparam logic [6:0] ADDR_CONTROL   = 7'h08;
	localparam logic [6:0] ADDR_INTERRUPT = 7'h44;

	// control word bits, relative to a channel's field
	localparam int CTL_RUN  = 0;
	localparam int CTL_UPD  = 1;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_NONE,
		REG_PRE,
		REG_DIV,
		REG_CTL,
		REG_INT,
		REG_BUF,
		REG_CMP,
		REG_CNT
	} reg_kind_t;

	typedef struct packed {
		reg_kind_t          kind;
		logic [CHAN_W-1:0]  chan;
	} reg_dec_t;

	typedef struct packed {
		op_t         op;
		logic [6:0]  address;
		logic [31:0] write_data;
		logic        ext_pulse;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [4:0]  irq_pending;
		logic        irq;
	} rsp_t;

	// bit position of a channel's run bit in the control word
	function automatic int ctl_shift(int n);
		return (n == 0) ? 0 : n * 4 + 4;
	endfunction

	// auto-reload bit offset within a channel's field (channel 4 is packed)
	function automatic int ctl_auto(int n);
		return (n == 4) ? 2 : 3;
	endfunction

	// writable control bits for a given channel count
	function automatic logic [CTL_W-1:0] ctl_mask(int nch);
		logic [CTL_W-1:0] m;
		m = '0;
		for (int n = 0; n < MAX_CHANNELS; n++) begin
			if (n < nch) begin
				unique case (n)
					0:       m = m | 23'h00000F;
					1:       m = m | 23'h000F00;
					2:       m = m | 23'h00F000;
					3:       m = m | 23'h0F0000;
					default: m = m | 23'h700000;
				endcase
			end
		end
		return m;
	endfunction

	// divider counter wrap mask for a mux select, zero for external clock
	function automatic logic [3:0] div_mask(logic [3:0] mux);
		logic [3:0] m;
		unique case (mux)
			4'd0:    m = 4'h0;
			4'd1:    m = 4'h1;
			4'd2:    m = 4'h3;
			4'd3:    m = 4'h7;
			4'd4:    m = 4'hF;
			default: m = 4'h0;
		endcase
		return m;
	endfunction

	// address decode, unaligned and unmapped offsets fall to REG_NONE
	function automatic reg_dec_t decode(logic [6:0] a);
		reg_dec_t d;
		d.kind = REG_NONE;
		d.chan = '0;
		unique case (a)
			ADDR_PRESCALE:  d.kind = REG_PRE;
			ADDR_DIVIDER:   d.kind = REG_DIV;
			ADDR_CONTROL:   d.kind = REG_CTL;
			ADDR_INTERRUPT: d.kind = REG_INT;
			7'h0C: begin d.kind = REG_BUF; d.chan = 3'd0; end
			7'h10: begin d.kind = REG_CMP; d.chan = 3'd0; end
			7'h14: begin d.kind = REG_CNT; d.chan = 3'd0; end
			7'h18: begin d.kind = REG_BUF; d.chan = 3'd1; end
			7'h1C: begin d.kind = REG_CMP; d.chan = 3'd1; end
			7'h20: begin d.kind = REG_CNT; d.chan = 3'd1; end
			7'h24: begin d.kind = REG_BUF; d.chan = 3'd2; end
			7'h28: begin d.kind = REG_CMP; d.chan = 3'd2; end
			7'h2C: begin d.kind = REG_CNT; d.chan = 3'd2; end
			7'h30: begin d.kind = REG_BUF; d.chan = 3'd3; end
			7'h34: begin d.kind = REG_CMP; d.chan = 3'd3; end
			7'h38: begin d.kind = REG_CNT; d.chan = 3'd3; end
			7'h3C: begin d.kind = REG_BUF; d.chan = 3'd4; end
			7'h40: begin d.kind = REG_CNT; d.chan = 3'd4; end
			default: ;
		endcase
		return d;
	endfunction

endpackage

// ----- design/mrt_clkgen.sv -----
// ----------------------------------------------------------------------------
// mrt_clkgen: prescalers and per-channel clock dividers
// turns input ticks into one count enable per channel
// ----------------------------------------------------------------------------
module mrt_clkgen #(
	parameter int NUM_CHANNELS = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tick,
	input  logic                      ext_pulse,
	input  logic [15:0]               pre_setting,
	input  logic [4*NUM_CHANNELS-1:0] div_select,
	output logic [NUM_CHANNELS-1:0]   chan_clk
);

	logic [7:0] pre_cnt_q [2];
	logic [7:0] pre_cnt_n [2];
	logic [1:0] pre_pulse;
	logic [3:0] div_cnt_q [NUM_CHANNELS];
	logic [3:0] div_cnt_n [NUM_CHANNELS];

	always_comb begin
		for (int g = 0; g < 2; g++) begin
			pre_pulse[g] = pre_cnt_q[g] >= pre_setting[8*g +: 8];
			pre_cnt_n[g] = pre_pulse[g] ? 8'd0 : pre_cnt_q[g] + 8'd1;
		end
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			div_cnt_n[i] = div_cnt_q[i];
			chan_clk[i]  = 1'b0;
			if (pre_pulse[(i < 2) ? 0 : 1]) begin
				div_cnt_n[i] = (div_cnt_q[i] + 4'd1) & mrt_pkg::div_mask(div_select[4*i +: 4]);
				chan_clk[i]  = (div_select[4*i +: 4] < 4'd5) && (div_cnt_n[i] == 4'd0);
			end
			// mux 5 and above counts external edges
			if (div_select[4*i +: 4] >= 4'd5) begin
				chan_clk[i] = ext_pulse;
			end
			chan_clk[i] = chan_clk[i] & tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < 2; g++) begin
				pre_cnt_q[g] <= '0;
			end
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				div_cnt_q[i] <= '0;
			end
		end else if (tick) begin
			for (int g = 0; g < 2; g++) begin
				pre_cnt_q[g] <= pre_cnt_n[g];
			end
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				div_cnt_q[i] <= div_cnt_n[i];
			end
		end
	end

endmodule

// ----- design/mrt_core.sv -----
// ----------------------------------------------------------------------------
// mrt_core: register file, channel counters and interrupt logic
// executes one transaction per enabled cycle and forms its response
// ----------------------------------------------------------------------------
module mrt_core #(
	parameter int NUM_CHANNELS = 5,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  mrt_pkg::req_t             req,
	input  logic [NUM_CHANNELS-1:0]   chan_clk,
	output logic [15:0]               pre_setting,
	output logic [4*NUM_CHANNELS-1:0] div_select,
	output mrt_pkg::rsp_t             rsp
);

	localparam int PRE_W   = (NUM_CHANNELS > 2) ? 16 : 8;
	localparam int DIV_W   = 4 * NUM_CHANNELS;
	localparam int NUM_CMP = (NUM_CHANNELS < 4) ? NUM_CHANNELS : 4;
	localparam logic [mrt_pkg::CTL_W-1:0] CTL_MASK = mrt_pkg::ctl_mask(NUM_CHANNELS);

	logic [PRE_W-1:0]          pre_q, pre_n;
	logic [DIV_W-1:0]          div_q, div_n;
	logic [mrt_pkg::CTL_W-1:0] ctl_q, ctl_n;
	logic [COUNT_WIDTH-1:0]    reload_q [NUM_CHANNELS];
	logic [COUNT_WIDTH-1:0]    reload_n [NUM_CHANNELS];
	logic [COUNT_WIDTH-1:0]    cmp_q    [NUM_CMP];
	logic [COUNT_WIDTH-1:0]    cmp_n    [NUM_CMP];
	logic [COUNT_WIDTH-1:0]    count_q  [NUM_CHANNELS];
	logic [COUNT_WIDTH-1:0]    count_n  [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]   ien_q, ien_n;
	logic [NUM_CHANNELS-1:0]   ist_q, ist_n;
	logic [NUM_CHANNELS-1:0]   pend;
	logic [31:0]               rd;
	mrt_pkg::reg_dec_t         dec;

	assign dec         = mrt_pkg::decode(req.address);
	assign pre_setting = 16'(pre_q);
	assign div_select  = div_q;

	always_comb begin
		pre_n = pre_q;
		div_n = div_q;
		ctl_n = ctl_q;
		ien_n = ien_q;
		ist_n = ist_q;
		rd    = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			reload_n[i] = reload_q[i];
			count_n[i]  = count_q[i];
		end
		for (int i = 0; i < NUM_CMP; i++) begin
			cmp_n[i] = cmp_q[i];
		end

		unique case (req.op)
			mrt_pkg::OP_READ: begin
				unique case (dec.kind)
					mrt_pkg::REG_PRE: rd = 32'(pre_q);
					mrt_pkg::REG_DIV: rd = 32'(div_q);
					mrt_pkg::REG_CTL: rd = 32'(ctl_q);
					mrt_pkg::REG_INT: rd = 32'(ien_q) | (32'(ist_q) << 5);
					mrt_pkg::REG_BUF: begin
						for (int i = 0; i < NUM_CHANNELS; i++) begin
							if (dec.chan == mrt_pkg::CHAN_W'(i)) rd = 32'(reload_q[i]);
						end
					end
					mrt_pkg::REG_CMP: begin
						for (int i = 0; i < NUM_CMP; i++) begin
							if (dec.chan == mrt_pkg::CHAN_W'(i)) rd = 32'(cmp_q[i]);
						end
					end
					mrt_pkg::REG_CNT: begin
						for (int i = 0; i < NUM_CHANNELS; i++) begin
							if (dec.chan == mrt_pkg::CHAN_W'(i)) rd = 32'(count_q[i]);
						end
					end
					default: rd = '0;
				endcase
			end
			mrt_pkg::OP_WRITE: begin
				unique case (dec.kind)
					mrt_pkg::REG_PRE: pre_n = req.write_data[PRE_W-1:0];
					mrt_pkg::REG_DIV: div_n = req.write_data[DIV_W-1:0];
					mrt_pkg::REG_CTL: begin
						ctl_n = req.write_data[mrt_pkg::CTL_W-1:0] & CTL_MASK;
						// manual update loads the count from its buffer
						for (int i = 0; i < NUM_CHANNELS; i++) begin
							if (ctl_n[mrt_pkg::ctl_shift(i) + mrt_pkg::CTL_UPD]) begin
								count_n[i] = reload_q[i];
							end
						end
					end
					mrt_pkg::REG_INT: begin
						ien_n = req.write_data[NUM_CHANNELS-1:0];
						ist_n = ist_q & ~req.write_data[5 +: NUM_CHANNELS];
					end
					mrt_pkg::REG_BUF: begin
						for (int i = 0; i < NUM_CHANNELS; i++) begin
							if (dec.chan == mrt_pkg::CHAN_W'(i)) begin
								reload_n[i] = req.write_data[COUNT_WIDTH-1:0];
							end
						end
					end
					mrt_pkg::REG_CMP: begin
						for (int i = 0; i < NUM_CMP; i++) begin
							if (dec.chan == mrt_pkg::CHAN_W'(i)) begin
								cmp_n[i] = req.write_data[COUNT_WIDTH-1:0];
							end
						end
					end
					default: ;
				endcase
			end
			mrt_pkg::OP_TICK: begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (chan_clk[i] && ctl_q[mrt_pkg::ctl_shift(i) + mrt_pkg::CTL_RUN]
						&& !ctl_q[mrt_pkg::ctl_shift(i) + mrt_pkg::CTL_UPD]) begin
						if (count_q[i] == '0) begin
							// expiry: flag, then reload or stop
							ist_n[i] = 1'b1;
							if (ctl_q[mrt_pkg::ctl_shift(i) + mrt_pkg::ctl_auto(i)]) begin
								count_n[i] = reload_q[i];
							end else begin
								ctl_n[mrt_pkg::ctl_shift(i) + mrt_pkg::CTL_RUN] = 1'b0;
							end
						end else begin
							count_n[i] = count_q[i] - 1'b1;
						end
					end
				end
			end
			default: ;
		endcase

		pend            = ist_n & ien_n;
		rsp.read_data   = rd;
		rsp.irq_pending = 5'(pend);
		rsp.irq         = |pend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q <= '0;
			div_q <= '0;
			ctl_q <= '0;
			ien_q <= '0;
			ist_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				reload_q[i] <= '0;
				count_q[i]  <= '0;
			end
			for (int i = 0; i < NUM_CMP; i++) begin
				cmp_q[i] <= '0;
			end
		end else if (fire) begin
			pre_q <= pre_n;
			div_q <= div_n;
			ctl_q <= ctl_n;
			ien_q <= ien_n;
			ist_q <= ist_n;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				reload_q[i] <= reload_n[i];
				count_q[i]  <= count_n[i];
			end
			for (int i = 0; i < NUM_CMP; i++) begin
				cmp_q[i] <= cmp_n[i];
			end
		end
	end

endmodule

// ----- design/multichannel_reload_timer.sv -----
// ----------------------------------------------------------------------------
// multichannel_reload_timer: five-channel reload timer behind a register port
// path: a taken request waits in the input register, then one pass of logic
//   fills the response register when the response slot is free or draining
// throughput: one transaction per cycle unless stalled (single execute pass)
// reset: arst_n clears every register, count, prescaler and divider to zero
//   and empties both handshake stages; all channels come up stopped
// ----------------------------------------------------------------------------
module multichannel_reload_timer #(
	parameter int NUM_CHANNELS = 5,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  mrt_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mrt_pkg::rsp_t rsp_data
);

	// input register
	logic          valid_s1;
	mrt_pkg::req_t req_s1;

	// execute enable: an item waits and the response slot is free or draining
	logic fire;
	logic tick;

	logic [NUM_CHANNELS-1:0]   chan_clk;
	logic [15:0]               pre_setting;
	logic [4*NUM_CHANNELS-1:0] div_select;
	mrt_pkg::rsp_t             rsp_next;

	// response register
	logic          rsp_valid_s2;
	mrt_pkg::rsp_t rsp_s2;

	assign fire      = valid_s1 && (!rsp_valid_s2 || rsp_ready);
	assign tick      = fire && (req_s1.op == mrt_pkg::OP_TICK);
	// the input stage refills in the same cycle it drains
	assign req_ready = !valid_s1 || fire;
	assign rsp_valid = rsp_valid_s2;
	assign rsp_data  = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// payload needs no reset, only loaded on a taken transaction
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_data;
		end
	end

	mrt_clkgen #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_clkgen (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.ext_pulse  (req_s1.ext_pulse),
		.pre_setting(pre_setting),
		.div_select (div_select),
		.chan_clk   (chan_clk)
	);

	mrt_core #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.req        (req_s1),
		.chan_clk   (chan_clk),
		.pre_setting(pre_setting),
		.div_select (div_select),
		.rsp        (rsp_next)
	);

	// response slot: filled on execute, emptied when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (fire) begin
			rsp_valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_s2 <= rsp_next;
		end
	end

endmodule

// ----- design/mrt_checker.sv -----
// ----------------------------------------------------------------------------
// mrt_checker: port-level checks for the multichannel reload timer
// response stability, interrupt summary and input backpressure
// ----------------------------------------------------------------------------
module mrt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input mrt_pkg::rsp_t rsp_data
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// irq is the or of the pending bits
	a_irq_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.irq == (rsp_data.irq_pending != 5'd0)))
		else $error("irq does not match pending bits");

	// requests only back up behind a stalled response
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request stalled with response side free");

	// with the response side free, a request is never refused
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !rsp_valid |-> req_ready)
		else $error("request refused while response side idle");

endmodule

bind multichannel_reload_timer mrt_checker u_mrt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp_data (rsp_data)
);

// ----- tb/sv/reload_timer_checker.sv -----
// ----------------------------------------------------------------------------
// reload_timer_checker: response predictor and comparator for the timer
// watches both channels, mirrors the register file and the channel counters
// per accepted request and checks each accepted response in order
// ----------------------------------------------------------------------------
module reload_timer_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  mrt_pkg::req_t req_data,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  mrt_pkg::rsp_t rsp_data,
	output int            fail_count,
	output int            pending
);

	localparam int NCH             = 5;
	localparam int STAT_LSB        = 5;
	localparam int AUTO_BIT        = 3;
	localparam int AUTO_BIT_PACKED = 2;
	localparam int CHAN_STRIDE     = 12;
	localparam int SLOT_BUF        = 0;
	localparam int SLOT_CMP        = 4;
	localparam int REPORT_MAX      = 10;
	localparam logic [6:0]                ADDR_CHAN_BASE = 7'h0C;
	localparam logic [mrt_pkg::CTL_W-1:0] CTL_WRITABLE   = 23'h7FFF0F;

	logic [15:0]               prescale;
	logic [19:0]               div_sel;
	logic [mrt_pkg::CTL_W-1:0] ctl;
	logic [31:0]               reload  [NCH];
	logic [31:0]               compare [NCH-1];
	logic [31:0]               count   [NCH];
	logic [7:0]                pre_cnt [2];
	logic [3:0]                div_cnt [NCH];
	logic [4:0]                irq_en;
	logic [4:0]                irq_st;
	mrt_pkg::rsp_t             predicted_rsp [$];
	int                        mismatch_cnt = 0;

	function automatic int field_base(int n);
		return (n == 0) ? 0 : 4 * n + 4;
	endfunction

	task automatic clear_state();
		prescale = '0;
		div_sel  = '0;
		ctl      = '0;
		irq_en   = '0;
		irq_st   = '0;
		for (int i = 0; i < NCH; i++) begin
			reload[i]  = '0;
			count[i]   = '0;
			div_cnt[i] = '0;
		end
		for (int i = 0; i < NCH - 1; i++)
			compare[i] = '0;
		pre_cnt[0] = '0;
		pre_cnt[1] = '0;
	endtask

	task automatic timer_tick(input logic ext);
		logic [1:0] pulse;
		logic [3:0] mux;
		logic [3:0] wrap;
		logic       chan_clk;
		int         base;
		int         auto_bit;
		for (int g = 0; g < 2; g++) begin
			if (pre_cnt[g] >= prescale[8*g +: 8]) begin
				pre_cnt[g] = '0;
				pulse[g]   = 1'b1;
			end else begin
				pre_cnt[g] = pre_cnt[g] + 8'd1;
				pulse[g]   = 1'b0;
			end
		end
		for (int n = 0; n < NCH; n++) begin
			mux      = div_sel[4*n +: 4];
			base     = field_base(n);
			auto_bit = base + ((n == NCH - 1) ? AUTO_BIT_PACKED : AUTO_BIT);
			chan_clk = 1'b0;
			if (pulse[(n < 2) ? 0 : 1]) begin
				wrap       = (mux < 4'd5) ? 4'((1 << mux) - 1) : 4'd0;
				div_cnt[n] = (div_cnt[n] + 4'd1) & wrap;
				if (mux < 4'd5 && div_cnt[n] == 4'd0)
					chan_clk = 1'b1;
			end
			if (mux >= 4'd5)
				chan_clk = ext;
			if (chan_clk && ctl[base + mrt_pkg::CTL_RUN] && !ctl[base + mrt_pkg::CTL_UPD]) begin
				if (count[n] == '0) begin
					irq_st[n] = 1'b1;
					if (ctl[auto_bit])
						count[n] = reload[n];
					else
						ctl[base + mrt_pkg::CTL_RUN] = 1'b0;
				end else begin
					count[n] = count[n] - 32'd1;
				end
			end
		end
	endtask

	function automatic logic [31:0] reg_read(logic [6:0] a);
		int off;
		int n;
		int slot;
		if (a[1:0] != 2'b00)
			return '0;
		case (a)
			mrt_pkg::ADDR_PRESCALE:  return 32'(prescale);
			mrt_pkg::ADDR_DIVIDER:   return 32'(div_sel);
			mrt_pkg::ADDR_CONTROL:   return 32'(ctl);
			mrt_pkg::ADDR_INTERRUPT: return 32'({irq_st, irq_en});
			default: ;
		endcase
		if (a < ADDR_CHAN_BASE || a > mrt_pkg::ADDR_INTERRUPT)
			return '0;
		off  = int'(a) - int'(ADDR_CHAN_BASE);
		n    = off / CHAN_STRIDE;
		slot = off % CHAN_STRIDE;
		if (slot == SLOT_BUF)
			return reload[n];
		if (n == NCH - 1)
			return count[n];
		if (slot == SLOT_CMP)
			return compare[n];
		return count[n];
	endfunction

	task automatic reg_write(input logic [6:0] a, input logic [31:0] d);
		int off;
		int n;
		int slot;
		if (a[1:0] == 2'b00) begin
			case (a)
				mrt_pkg::ADDR_PRESCALE: prescale = d[15:0];
				mrt_pkg::ADDR_DIVIDER:  div_sel  = d[19:0];
				mrt_pkg::ADDR_CONTROL: begin
					ctl = d[mrt_pkg::CTL_W-1:0] & CTL_WRITABLE;
					// manual update copies the buffer into the count
					for (int i = 0; i < NCH; i++)
						if (ctl[field_base(i) + mrt_pkg::CTL_UPD])
							count[i] = reload[i];
				end
				mrt_pkg::ADDR_INTERRUPT: begin
					irq_en = d[4:0];
					irq_st = irq_st & ~d[STAT_LSB +: 5];
				end
				default: begin
					if (a >= ADDR_CHAN_BASE && a < mrt_pkg::ADDR_INTERRUPT) begin
						off  = int'(a) - int'(ADDR_CHAN_BASE);
						n    = off / CHAN_STRIDE;
						slot = off % CHAN_STRIDE;
						if (slot == SLOT_BUF)
							reload[n] = d;
						else if (slot == SLOT_CMP && n < NCH - 1)
							compare[n] = d;
					end
				end
			endcase
		end
	endtask

	task automatic timer_step(input mrt_pkg::req_t r, output mrt_pkg::rsp_t e);
		e = '0;
		case (r.op)
			mrt_pkg::OP_READ:  e.read_data = reg_read(r.address);
			mrt_pkg::OP_WRITE: reg_write(r.address, r.write_data);
			mrt_pkg::OP_TICK:  timer_tick(r.ext_pulse);
			default: ;
		endcase
		e.irq_pending = irq_st & irq_en;
		e.irq         = |e.irq_pending;
	endtask

	always @(posedge clk) begin : track
		mrt_pkg::rsp_t want;
		if (!arst_n) begin
			clear_state();
			predicted_rsp.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (predicted_rsp.size() == 0) begin
					if (mismatch_cnt < REPORT_MAX)
						$display("%0t: response with none outstanding: %h",
							$realtime, rsp_data);
					mismatch_cnt++;
				end else begin
					want = predicted_rsp.pop_front();
					if (rsp_data.read_data !== want.read_data ||
							rsp_data.irq_pending !== want.irq_pending ||
							rsp_data.irq !== want.irq) begin
						if (mismatch_cnt < REPORT_MAX)
							$display("%0t: mismatch read_data exp %h got %h, ",
								$realtime, want.read_data, rsp_data.read_data,
								"irq_pending exp %b got %b, irq exp %b got %b",
								want.irq_pending, rsp_data.irq_pending,
								want.irq, rsp_data.irq);
						mismatch_cnt++;
					end
				end
			end
			if (req_valid && req_ready) begin
				timer_step(req_data, want);
				predicted_rsp.push_back(want);
			end
		end
		fail_count <= mismatch_cnt;
		pending    <= predicted_rsp.size();
	end

endmodule

// ----- tb/sv/multichannel_reload_timer_tb.sv -----
// ----------------------------------------------------------------------------
// multichannel_reload_timer_tb: top of the timer testbench
// a short directed pass over the register map and the expiry path, then
// random timer scenes and register noise with random stalls on both sides;
// the checker beside the block predicts and compares every response
// ----------------------------------------------------------------------------
module multichannel_reload_timer_tb;

	localparam int CLK_PERIOD      = 8;
	localparam int NUM_CH          = 5;
	localparam int ITEM_TARGET     = 850;
	localparam int TAIL_ITEMS      = 120;
	localparam int HOLD_AFTER      = 200;
	localparam int HOLD_CYCLES     = 90;
	localparam int DRAIN_CYCLES    = 12;
	localparam int LIMIT_CYCLES    = 400000;
	localparam int AUTO_BIT        = 3;
	localparam int AUTO_BIT_PACKED = 2;
	localparam int STAT_LSB        = 5;
	localparam int CHAN_STRIDE     = 12;

	// per-channel register offsets; channel 4 has no compare buffer
	localparam logic [6:0] ADDR_BUF0     = 7'h0C;
	localparam logic [6:0] ADDR_CMP0     = 7'h10;
	localparam logic [6:0] ADDR_CNT0     = 7'h14;
	localparam logic [6:0] ADDR_CNT4     = 7'h40;
	localparam logic [6:0] ADDR_UNALIGN  = 7'h45;
	localparam logic [6:0] ADDR_UNMAPPED = 7'h48;
	localparam logic [6:0] ADDR_TOP      = 7'h7C;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	mrt_pkg::req_t req_data;
	logic          rsp_valid;
	logic          rsp_ready;
	mrt_pkg::rsp_t rsp_data;
	int            fail_count;
	int            pending;

	mrt_pkg::req_t stim_q [$];
	bit            tail_phase = 1'b0;
	bit            rsp_hold   = 1'b0;
	bit            stim_done  = 1'b0;

	multichannel_reload_timer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	reload_timer_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp_data   (rsp_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// single reset at the start, released on a clock edge
	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// control field of channel n starts at bit 0, or 4n+4 for n > 0
	function automatic int field_base(int n);
		return (n == 0) ? 0 : 4 * n + 4;
	endfunction

	function automatic logic [6:0] buf_addr(int n);
		return 7'(int'(ADDR_BUF0) + CHAN_STRIDE * n);
	endfunction

	function automatic logic [6:0] cmp_addr(int n);
		return 7'(int'(ADDR_CMP0) + CHAN_STRIDE * n);
	endfunction

	function automatic logic [6:0] cnt_addr(int n);
		return (n == NUM_CH - 1) ? ADDR_CNT4 : 7'(int'(ADDR_CNT0) + CHAN_STRIDE * n);
	endfunction

	function automatic void add_item(mrt_pkg::op_t op, logic [6:0] a, logic [31:0] d,
		logic ext);
		mrt_pkg::req_t r;
		r.op         = op;
		r.address    = a;
		r.write_data = d;
		r.ext_pulse  = ext;
		stim_q.push_back(r);
	endfunction

	// request side: build the whole stimulus, then offer it transaction by transaction
	initial begin : drive
		logic [31:0] word;
		int          base;
		req_valid = 1'b0;
		req_data  = '0;

		// reset values, then prescale, divider, a buffer, a compare and control at all ones
		add_item(mrt_pkg::OP_READ,  mrt_pkg::ADDR_INTERRUPT, '0, 1'b0);
		add_item(mrt_pkg::OP_READ,  ADDR_CNT4, '0, 1'b0);
		add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_PRESCALE, '1, 1'b0);
		add_item(mrt_pkg::OP_READ,  mrt_pkg::ADDR_PRESCALE, '0, 1'b0);
		add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_DIVIDER, '1, 1'b0);
		add_item(mrt_pkg::OP_READ,  mrt_pkg::ADDR_DIVIDER, '0, 1'b0);
		add_item(mrt_pkg::OP_WRITE, buf_addr(NUM_CH - 1), '1, 1'b0);
		add_item(mrt_pkg::OP_WRITE, cmp_addr(0), '1, 1'b0);
		add_item(mrt_pkg::OP_READ,  cmp_addr(0), '0, 1'b0);
		// all update bits set: counts load from their buffers
		add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_CONTROL, '1, 1'b0);
		add_item(mrt_pkg::OP_READ,  mrt_pkg::ADDR_CONTROL, '0, 1'b0);
		// count readback is read-only
		add_item(mrt_pkg::OP_WRITE, ADDR_CNT4, 32'h5A5A_5A5A, 1'b0);
		add_item(mrt_pkg::OP_READ,  ADDR_CNT4, '0, 1'b0);
		// unaligned and unmapped offsets
		add_item(mrt_pkg::OP_WRITE, ADDR_UNALIGN, '1, 1'b1);
		add_item(mrt_pkg::OP_READ,  ADDR_UNALIGN + 7'd1, '0, 1'b0);
		add_item(mrt_pkg::OP_WRITE, ADDR_TOP, '1, 1'b0);
		add_item(mrt_pkg::OP_READ,  ADDR_UNMAPPED, '1, 1'b1);
		add_item(mrt_pkg::OP_NOP,   ADDR_TOP, '1, 1'b1);
		// channel 0 runs from count zero without reload: expires on the first tick
		add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_PRESCALE, '0, 1'b0);
		add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_DIVIDER, '0, 1'b0);
		add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_INTERRUPT, '1, 1'b0);
		add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_CONTROL, 32'(1 << mrt_pkg::CTL_RUN), 1'b0);
		add_item(mrt_pkg::OP_TICK,  '0, '0, 1'b0);
		add_item(mrt_pkg::OP_READ,  mrt_pkg::ADDR_INTERRUPT, '0, 1'b0);
		add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_INTERRUPT, 32'h1F << STAT_LSB, 1'b0);

		while (stim_q.size() < ITEM_TARGET) begin
			if ($urandom_range(0, 4) == 0) begin
				// register noise: any op, any offset, any data
				repeat ($urandom_range(4, 16))
					add_item(mrt_pkg::op_t'(2'($urandom_range(0, 3))),
						7'($urandom_range(0, 127)), $urandom, 1'($urandom));
			end else begin
				// timer scene: small prescale and divide, short periods
				word = $urandom;
				word[7:0]  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
				word[15:8] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
				add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_PRESCALE, word, 1'($urandom));
				word = $urandom;
				for (int n = 0; n < NUM_CH; n++) begin
					if ($urandom_range(0, 3) == 0)
						word[4*n +: 4] = 4'($urandom_range(5, 15));
					else if ($urandom_range(0, 9) == 0)
						word[4*n +: 4] = 4'($urandom_range(3, 4));
					else
						word[4*n +: 4] = 4'($urandom_range(0, 2));
				end
				add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_DIVIDER, word, 1'($urandom));
				for (int n = 0; n < NUM_CH; n++)
					if ($urandom_range(0, 1))
						add_item(mrt_pkg::OP_WRITE, buf_addr(n),
							($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 7)),
							1'($urandom));
				add_item(mrt_pkg::OP_WRITE, cmp_addr($urandom_range(0, NUM_CH - 2)), $urandom,
					1'($urandom));
				add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_INTERRUPT, $urandom, 1'($urandom));
				// load counts through manual update, most of the time
				if ($urandom_range(0, 3) != 0) begin
					word = $urandom;
					for (int n = 0; n < NUM_CH; n++)
						word[field_base(n) + mrt_pkg::CTL_UPD] = 1'b1;
					add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_CONTROL, word, 1'($urandom));
				end
				// start: run and auto-reload at random, update mostly released
				word = $urandom;
				for (int n = 0; n < NUM_CH; n++) begin
					base = field_base(n);
					word[base + mrt_pkg::CTL_RUN] = ($urandom_range(0, 3) != 0);
					word[base + mrt_pkg::CTL_UPD] = ($urandom_range(0, 9) == 0);
					word[base + ((n == NUM_CH - 1) ? AUTO_BIT_PACKED : AUTO_BIT)] =
						1'($urandom_range(0, 1));
				end
				add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_CONTROL, word, 1'($urandom));
				// tick burst with readbacks and status clears mixed in
				repeat ($urandom_range(15, 60)) begin
					case ($urandom_range(0, 11))
						0: add_item(mrt_pkg::OP_READ, cnt_addr($urandom_range(0, NUM_CH - 1)),
							$urandom, 1'($urandom));
						1: add_item(mrt_pkg::OP_READ, mrt_pkg::ADDR_INTERRUPT, $urandom,
							1'($urandom));
						2: add_item(mrt_pkg::OP_WRITE, mrt_pkg::ADDR_INTERRUPT, $urandom,
							1'($urandom));
						3: add_item(mrt_pkg::OP_READ, 7'($urandom_range(0, 17) * 4), $urandom,
							1'($urandom));
						default: add_item(mrt_pkg::OP_TICK, 7'($urandom), $urandom, 1'($urandom));
					endcase
				end
			end
		end

		wait (arst_n === 1'b1);
		@(posedge clk);
		for (int i = 0; i < stim_q.size(); i++) begin
			// the last stretch runs with no idling on either side
			if (i == stim_q.size() - TAIL_ITEMS)
				tail_phase = 1'b1;
			if (!tail_phase && !rsp_hold && $urandom_range(0, 11) == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			req_valid <= 1'b1;
			req_data  <= stim_q[i];
			do @(posedge clk); while (!req_ready);
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// response side: random stall bursts, plus one long hold-off so the
	// block fills up and backpressures the request channel
	initial begin : sink
		int stall;
		int accepted;
		bit held;
		rsp_ready = 1'b0;
		stall     = 0;
		accepted  = 0;
		held      = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				accepted++;
			if (!held && accepted >= HOLD_AFTER) begin
				held      = 1'b1;
				rsp_hold  = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_hold  = 1'b0;
			end else if (stall > 0) begin
				stall--;
				rsp_ready <= 1'b0;
			end else if (!tail_phase && $urandom_range(0, 11) == 0) begin
				stall     = $urandom_range(1, 18) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// verdict once every transaction is in and the pipeline has drained
	initial begin : verdict
		wait (stim_done);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("multichannel_reload_timer test passed");
		else
			$display("multichannel_reload_timer test failed");
		$finish;
	end

	// hard stop in case the handshake hangs
	initial begin : watchdog
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("multichannel_reload_timer test failed");
		$finish;
	end

endmodule
